@@ rtl/csnq_pkg.sv @@
// Shared types and constants for the C-style name quoter.
// Used by csnq_front, csnq_queue, csnq_back and the c_style_name_quoter top level.
// No dependencies.
package csnq_pkg;

  localparam int unsigned MAX_NAME_BYTES = 4096;
  localparam int unsigned NAME_CNT_W     = $clog2(MAX_NAME_BYTES + 1);

  localparam int unsigned LEN_W       = 15;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned RES_CNT_W   = 3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_DEL       = 8'h7F;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;

  // One work unit for the back end: the result bytes of one input transaction.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [RES_CNT_W-1:0]        nres;
    logic                        byte_valid;
    logic                        name_end;
    logic                        needs_quoting;
    logic [LEN_W-1:0]            quoted_length;
  } job_t;

endpackage

@@ rtl/c_style_name_quoter.sv @@
// Top level of the C-style name quoter: stream ports and configuration bit.
// Instantiates csnq_front, csnq_queue and csnq_back; uses csnq_pkg.
//
// The block takes a name one byte per input transaction and returns its
// C-style quoted form one byte per output transaction. An input byte is
// accepted in any cycle in which the two-entry job queue has room, so bytes
// may arrive back to back. The output stage delivers one result per cycle
// while m_axis_tready is high. A byte has one result if plain, two for a
// letter or backslash escape, four for an octal escape, plus one for each
// enclosing quote, at most six; that serializer sets the sustained rate. A
// byte that yields no result (after a NUL, past the length bound) takes no
// output transaction. The final result of a name carries tlast, needs_quoting
// and the quoted length; there is no clearing pass after reset. The user must
// change omit_double_quotes only while idle; the block does not enforce it.
module c_style_name_quoter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // omit_double_quotes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] run_end,
                                      // [9] needs_quoting, [24:10] quoted_length, rest 0
  output logic        m_axis_tlast,   // name_end
  output logic        m_axis_tuser    // byte_valid
);

  logic                       omit_dq;
  logic                       accept;
  logic                       push;
  logic                       pop;
  logic                       full;
  logic                       not_empty;
  csnq_pkg::job_t             push_job;
  csnq_pkg::job_t             head;
  logic [7:0]                 out_byte;
  logic                       run_end;
  logic                       needs_quoting;
  logic [csnq_pkg::LEN_W-1:0] quoted_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      omit_dq <= 1'b0;
    end else if (cfg_we) begin
      omit_dq <= cfg_wdata;
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  csnq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .omit_dq    (omit_dq),
    .accept     (accept),
    .in_byte    (s_axis_tdata),
    .first_byte (s_axis_tuser),
    .last_byte  (s_axis_tlast),
    .push       (push),
    .job        (push_job)
  );

  csnq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  csnq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (not_empty),
    .job           (head),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (out_byte),
    .byte_valid    (m_axis_tuser),
    .run_end       (run_end),
    .name_end      (m_axis_tlast),
    .needs_quoting (needs_quoting),
    .quoted_length (quoted_length)
  );

  assign m_axis_tdata = {7'd0, quoted_length, needs_quoting, run_end, out_byte};

endmodule

@@ rtl/csnq_front.sv @@
// Front end of the quoter: tracks per-name state and turns one input byte
// into a job of up to six result bytes. Depends on csnq_pkg.
module csnq_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            omit_dq,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            first_byte,
  input  logic            last_byte,
  output logic            push,
  output csnq_pkg::job_t  job
);

  logic                            stopped;
  logic                            escape_seen;
  logic [csnq_pkg::LEN_W-1:0]      emitted_count;
  logic [csnq_pkg::NAME_CNT_W-1:0] name_bytes;

  logic                            stopped_next;
  logic                            escape_seen_next;
  logic [csnq_pkg::LEN_W-1:0]      emitted_count_next;
  logic [csnq_pkg::NAME_CNT_W-1:0] name_bytes_next;

  logic                            stopped_eff;
  logic                            escape_eff;
  logic [csnq_pkg::LEN_W-1:0]      count_eff;
  logic [csnq_pkg::NAME_CNT_W-1:0] nb_eff;
  logic                            active;
  logic                            hit_end;
  logic                            esc;
  logic [3:0][7:0]                 core;
  logic [2:0]                      core_n;
  logic [7:0]                      letter;
  logic                            open_q;
  logic                            close_q;
  logic [2:0]                      nvalid;
  logic [2:0]                      k;
  logic [csnq_pkg::LEN_W:0]        sum;
  logic [csnq_pkg::LEN_W-1:0]      count_new;
  logic                            escape_new;

  function automatic logic [7:0] letter_for(input logic [7:0] b);
    case (b)
      8'h07:   letter_for = 8'h61;  // a
      8'h08:   letter_for = 8'h62;  // b
      8'h0C:   letter_for = 8'h66;  // f
      8'h0A:   letter_for = 8'h6E;  // n
      8'h0D:   letter_for = 8'h72;  // r
      8'h09:   letter_for = 8'h74;  // t
      8'h0B:   letter_for = 8'h76;  // v
      default: letter_for = 8'h00;
    endcase
  endfunction

  always_comb begin
    // A first mark restarts the name before the byte is looked at.
    stopped_eff = first_byte ? 1'b0 : stopped;
    escape_eff  = first_byte ? 1'b0 : escape_seen;
    count_eff   = first_byte ? '0 : emitted_count;
    nb_eff      = first_byte ? '0 : name_bytes;

    hit_end = (in_byte == 8'h00) ||
              (nb_eff >= csnq_pkg::NAME_CNT_W'(csnq_pkg::MAX_NAME_BYTES));
    active  = !stopped_eff && !hit_end;

    letter = letter_for(in_byte);
    core   = '0;
    core_n = 3'd0;
    esc    = 1'b0;
    if (active) begin
      if (in_byte == csnq_pkg::CHAR_DQUOTE || in_byte == csnq_pkg::CHAR_BACKSLASH) begin
        esc     = 1'b1;
        core[0] = csnq_pkg::CHAR_BACKSLASH;
        core[1] = in_byte;
        core_n  = 3'd2;
      end else if (in_byte >= csnq_pkg::CHAR_SPACE && in_byte < csnq_pkg::CHAR_DEL) begin
        core[0] = in_byte;
        core_n  = 3'd1;
      end else if (letter != 8'h00) begin
        esc     = 1'b1;
        core[0] = csnq_pkg::CHAR_BACKSLASH;
        core[1] = letter;
        core_n  = 3'd2;
      end else begin
        esc     = 1'b1;
        core[0] = csnq_pkg::CHAR_BACKSLASH;
        core[1] = csnq_pkg::CHAR_ZERO + {6'd0, in_byte[7:6]};
        core[2] = csnq_pkg::CHAR_ZERO + {5'd0, in_byte[5:3]};
        core[3] = csnq_pkg::CHAR_ZERO + {5'd0, in_byte[2:0]};
        core_n  = 3'd4;
      end
    end

    open_q  = first_byte && !omit_dq;
    close_q = last_byte && !omit_dq;
    nvalid  = core_n + {2'd0, open_q} + {2'd0, close_q};

    // Opening quote, then the byte's encoding, then the closing quote.
    for (int i = 0; i < csnq_pkg::MAX_RESULTS; i++) begin
      k = 3'(i) - {2'd0, open_q};
      if (open_q && i == 0) begin
        job.bytes[i] = csnq_pkg::CHAR_DQUOTE;
      end else if (k < core_n) begin
        job.bytes[i] = core[k[1:0]];
      end else if (close_q && k == core_n) begin
        job.bytes[i] = csnq_pkg::CHAR_DQUOTE;
      end else begin
        job.bytes[i] = 8'h00;
      end
    end

    sum        = {1'b0, count_eff} + {{(csnq_pkg::LEN_W-2){1'b0}}, nvalid};
    count_new  = (sum > {1'b0, csnq_pkg::LEN_MAX}) ? csnq_pkg::LEN_MAX
                                                    : sum[csnq_pkg::LEN_W-1:0];
    escape_new = escape_eff || esc;

    // A last mark with nothing to emit still yields one empty result.
    job.nres          = (nvalid == 3'd0 && last_byte) ? 3'd1 : nvalid;
    job.byte_valid    = (nvalid != 3'd0);
    job.name_end      = last_byte;
    job.needs_quoting = last_byte && escape_new;
    job.quoted_length = (last_byte && escape_new) ? count_new : '0;

    push = accept && (job.nres != 3'd0);

    if (last_byte) begin
      stopped_next       = 1'b0;
      escape_seen_next   = 1'b0;
      emitted_count_next = '0;
      name_bytes_next    = '0;
    end else begin
      stopped_next       = stopped_eff || hit_end;
      escape_seen_next   = escape_new;
      emitted_count_next = count_new;
      name_bytes_next    = nb_eff + csnq_pkg::NAME_CNT_W'(active);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped       <= 1'b0;
      escape_seen   <= 1'b0;
      emitted_count <= '0;
      name_bytes    <= '0;
    end else if (accept) begin
      stopped       <= stopped_next;
      escape_seen   <= escape_seen_next;
      emitted_count <= emitted_count_next;
      name_bytes    <= name_bytes_next;
    end
  end

endmodule

@@ rtl/csnq_queue.sv @@
// Short job queue between the front end and the back end of the quoter.
// Depends on csnq_pkg for the job type and depth.
module csnq_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csnq_pkg::job_t  push_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output csnq_pkg::job_t  head
);

  csnq_pkg::job_t                   entries [csnq_pkg::QUEUE_DEPTH];
  logic [csnq_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [csnq_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [csnq_pkg::QUEUE_CNT_W-1:0] count;

  assign full      = (count == csnq_pkg::QUEUE_CNT_W'(csnq_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

@@ rtl/csnq_back.sv @@
// Back end of the quoter: walks the head job into a registered output stage,
// one result per cycle while not stalled. Depends on csnq_pkg for the job type.
module csnq_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  csnq_pkg::job_t              job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic                        run_end,
  output logic                        name_end,
  output logic                        needs_quoting,
  output logic [csnq_pkg::LEN_W-1:0]  quoted_length
);

  logic [csnq_pkg::RES_CNT_W-1:0] idx;
  logic                           load;
  logic                           at_last;

  assign load    = job_valid && (!out_valid || out_ready);
  assign at_last = (idx == job.nres - 1'b1);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= at_last ? '0 : idx + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The report fields ride only on the final result of a job.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= job.bytes[idx];
      byte_valid    <= job.byte_valid;
      run_end       <= at_last;
      name_end      <= at_last && job.name_end;
      needs_quoting <= at_last && job.needs_quoting;
      quoted_length <= at_last ? job.quoted_length : '0;
    end
  end

endmodule
